FILE: rtl/mprc_pkg.sv
// Shared types, constants and helper functions for the macro primitive rotation block.
// Used by every module under rtl except mprc_checker; depends on nothing else.
package mprc_pkg;

    // Default parameter values.
    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    // Fixed arithmetic constants.
    localparam int ANG_FRAC    = 24;
    localparam int GUARD       = 8;
    localparam int ATAN_LEN    = 30;
    localparam int QUEUE_DEPTH = 2;

    // Working widths: point operand, angle, CORDIC register, rounded result, offset, wide sum.
    localparam int PW  = 35;
    localparam int ZW  = 33;
    localparam int CW  = 46;
    localparam int RW  = CW - GUARD;
    localparam int OW  = 34;
    localparam int SW  = 40;

    // Stream widths.
    localparam int S_TDATA_W = 224;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 104;

    // Primitive kinds carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_CIRCLE  = 2'd0,
        CMD_VECTOR  = 2'd1,
        CMD_CENTER  = 2'd2,
        CMD_LOWLEFT = 2'd3
    } cmd_t;

    // Exposure codes; every other code toggles.
    localparam logic [1:0] EXP_OFF = 2'd0;
    localparam logic [1:0] EXP_ON  = 2'd1;

    // One classified primitive, handed from the front to the back.
    typedef struct packed {
        cmd_t                    cmd;
        logic                    exposed;
        logic signed [31:0]      w;
        logic signed [31:0]      h;
        logic signed [31:0]      ax;
        logic signed [31:0]      ay;
        logic signed [31:0]      bx;
        logic signed [31:0]      by;
        logic signed [ZW-1:0]    z;
        logic                    neg;
    } q_entry_t;

    // Rotation unit request and response.
    typedef struct packed {
        logic                 start;
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
        logic                 extra;
        logic signed [ZW-1:0] z;
        logic                 neg;
    } rot_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
    } rot_rsp_t;

    // Perpendicular offset unit request and response.
    typedef struct packed {
        logic                 start;
        logic signed [RW-1:0] x1;
        logic signed [RW-1:0] y1;
        logic signed [RW-1:0] x2;
        logic signed [RW-1:0] y2;
        logic signed [31:0]   w;
    } norm_req_t;

    typedef struct packed {
        logic                 done;
        logic signed [OW-1:0] ox;
        logic signed [OW-1:0] oy;
    } norm_rsp_t;

    // Arctangent of 2^-i in degrees, Q.24.
    function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = 33'sd754974720;
            5'd1:  v = 33'sd445687602;
            5'd2:  v = 33'sd235489089;
            5'd3:  v = 33'sd119537938;
            5'd4:  v = 33'sd60000934;
            5'd5:  v = 33'sd30029717;
            5'd6:  v = 33'sd15018523;
            5'd7:  v = 33'sd7509720;
            5'd8:  v = 33'sd3754917;
            5'd9:  v = 33'sd1877466;
            5'd10: v = 33'sd938734;
            5'd11: v = 33'sd469367;
            5'd12: v = 33'sd234684;
            5'd13: v = 33'sd117342;
            5'd14: v = 33'sd58671;
            5'd15: v = 33'sd29335;
            5'd16: v = 33'sd14668;
            5'd17: v = 33'sd7334;
            5'd18: v = 33'sd3667;
            5'd19: v = 33'sd1833;
            5'd20: v = 33'sd917;
            5'd21: v = 33'sd458;
            5'd22: v = 33'sd229;
            5'd23: v = 33'sd115;
            5'd24: v = 33'sd57;
            5'd25: v = 33'sd29;
            5'd26: v = 33'sd14;
            5'd27: v = 33'sd7;
            5'd28: v = 33'sd4;
            5'd29: v = 33'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a wide signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
        logic [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/mprc_front.sv
// Front end: accepts primitive words, updates the exposure bit and reduces the angle.
// Depends on mprc_pkg; feeds mprc_queue.
module mprc_front #(
    parameter int FRAC_BITS = mprc_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mprc_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [mprc_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               q_push,
    input  logic                               q_full,
    output mprc_pkg::q_entry_t                 q_wdata
);

    localparam int AW = 36;
    localparam logic [AW-1:0] FULLQ = AW'(360) << FRAC_BITS;
    localparam logic signed [AW-1:0] FULLS  = FULLQ;
    localparam logic signed [AW-1:0] HALFS  = FULLQ >> 1;
    localparam logic signed [AW-1:0] QUARTS = FULLQ >> 2;
    localparam int KQ  = (FRAC_BITS < 17) ? 18 - FRAC_BITS : 1;
    localparam int JW  = (KQ > 1) ? $clog2(KQ) : 1;
    localparam int ZSH = mprc_pkg::ANG_FRAC - FRAC_BITS;

    typedef enum logic [5:0] {
        F_IDLE = 6'b000001,
        F_MOD  = 6'b000010,
        F_WRAP = 6'b000100,
        F_HALF = 6'b001000,
        F_FOLD = 6'b010000,
        F_PUSH = 6'b100000
    } f_state_t;

    f_state_t            state_reg, state_next;
    mprc_pkg::q_entry_t  ent_reg;
    logic [AW-1:0]       m_reg;
    logic signed [AW-1:0] r_reg;
    logic                asign_reg;
    logic [JW-1:0]       j_reg;
    logic                exp_reg, exp_next;

    logic signed [25:0]  ang_in;
    logic signed [AW-1:0] ang_ext;
    logic [AW-1:0]       step_sub;
    logic signed [AW-1:0] r_fold;
    logic signed [AW-1:0] z_sh;
    logic                fold_neg;

    assign s_tready = (state_reg == F_IDLE);
    assign q_push   = (state_reg == F_PUSH) && !q_full;
    assign q_wdata  = ent_reg;

    assign ang_in   = $signed(s_tdata[219:194]);
    assign ang_ext  = AW'(ang_in);
    assign step_sub = FULLQ << j_reg;

    // Quadrant fold into [-90, 90] degrees.
    always_comb begin
        r_fold   = r_reg;
        fold_neg = 1'b0;
        if (r_reg > QUARTS) begin
            r_fold   = r_reg - HALFS;
            fold_neg = 1'b1;
        end else if (r_reg < -QUARTS) begin
            r_fold   = r_reg + HALFS;
            fold_neg = 1'b1;
        end
        z_sh = r_fold <<< ZSH;
    end

    // Exposure bit update on an accepted word.
    always_comb begin
        exp_next = exp_reg;
        if (s_tvalid && s_tready) begin
            if (s_tdata[1:0] == mprc_pkg::EXP_OFF) begin
                exp_next = 1'b0;
            end else if (s_tdata[1:0] == mprc_pkg::EXP_ON) begin
                exp_next = 1'b1;
            end else begin
                exp_next = !exp_reg;
            end
        end
    end

    // Sequencer for the angle reduction steps.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE: if (s_tvalid) state_next = F_MOD;
            F_MOD:  if (j_reg == '0) state_next = F_WRAP;
            F_WRAP: state_next = F_HALF;
            F_HALF: state_next = F_FOLD;
            F_FOLD: state_next = F_PUSH;
            F_PUSH: if (!q_full) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            exp_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            exp_reg   <= exp_next;
        end
    end

    // Payload path: capture, truncated remainder by restoring subtraction, then wrap and fold.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            F_IDLE: begin
                ent_reg.cmd     <= mprc_pkg::cmd_t'(s_tuser[1:0]);
                ent_reg.exposed <= exp_next;
                ent_reg.w       <= $signed(s_tdata[33:2]);
                ent_reg.h       <= $signed(s_tdata[65:34]);
                ent_reg.ax      <= $signed(s_tdata[97:66]);
                ent_reg.ay      <= $signed(s_tdata[129:98]);
                ent_reg.bx      <= $signed(s_tdata[161:130]);
                ent_reg.by      <= $signed(s_tdata[193:162]);
                asign_reg       <= ang_in[25];
                m_reg           <= ang_in[25] ? AW'(-ang_ext) : AW'(ang_ext);
                j_reg           <= JW'(KQ - 1);
            end
            F_MOD: begin
                if (m_reg >= step_sub) begin
                    m_reg <= m_reg - step_sub;
                    r_reg <= asign_reg ? -$signed(m_reg - step_sub)
                                       : $signed(m_reg - step_sub);
                end else begin
                    r_reg <= asign_reg ? -$signed(m_reg) : $signed(m_reg);
                end
                if (j_reg != '0) j_reg <= j_reg - 1'b1;
            end
            F_WRAP: if (r_reg < 0) r_reg <= r_reg + FULLS;
            F_HALF: if (r_reg > HALFS) r_reg <= r_reg - FULLS;
            F_FOLD: begin
                ent_reg.z   <= z_sh[mprc_pkg::ZW-1:0];
                ent_reg.neg <= fold_neg;
            end
            F_PUSH: ;
            default: ;
        endcase
    end

endmodule

FILE: rtl/mprc_queue.sv
// Short queue of classified primitives between the front and the back.
// Depends on mprc_pkg for the entry type.
module mprc_queue #(
    parameter int DEPTH = mprc_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mprc_pkg::q_entry_t wdata,
    output logic               full,
    input  logic               pop,
    output mprc_pkg::q_entry_t rdata,
    output logic               empty
);

    localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    mprc_pkg::q_entry_t mem_reg [DEPTH];
    logic [PTW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0] count_reg;

    assign full  = (count_reg == CNW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= wdata;
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/mprc_cordic.sv
// Iterative rotation unit: gain prescale, one CORDIC step per cycle, rounding.
// Depends on mprc_pkg for the arctangent table and request types.
module mprc_cordic #(
    parameter int CORDIC_STEPS = mprc_pkg::CORDIC_STEPS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mprc_pkg::rot_req_t req,
    output mprc_pkg::rot_rsp_t rsp
);

    localparam int NSTEP = (CORDIC_STEPS < mprc_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                               : mprc_pkg::ATAN_LEN;
    localparam int IW = $clog2(NSTEP);
    localparam int PW = mprc_pkg::PW;
    localparam int CW = mprc_pkg::CW;
    localparam int RW = mprc_pkg::RW;
    localparam int ZW = mprc_pkg::ZW;
    localparam int PRESHIFT = 28 - mprc_pkg::GUARD;
    localparam logic signed [28:0] GAIN_Q28 = 29'sd163008219;
    localparam logic signed [CW-1:0] RND = CW'(1) <<< (mprc_pkg::GUARD - 1);

    typedef enum logic [3:0] {
        C_IDLE  = 4'b0001,
        C_SCALE = 4'b0010,
        C_ITER  = 4'b0100,
        C_ROUND = 4'b1000
    } c_state_t;

    c_state_t             state_reg, state_next;
    logic signed [PW-1:0] xn_reg, yn_reg;
    logic                 extra_reg;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [IW-1:0]        i_reg;
    logic                 done_reg;
    logic signed [RW-1:0] rx_reg, ry_reg;

    logic signed [63:0]   px, py;
    logic signed [CW-1:0] xs, ys, xr, yr;

    assign px = xn_reg * GAIN_Q28;
    assign py = yn_reg * GAIN_Q28;
    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign xr = (x_reg + RND) >>> mprc_pkg::GUARD;
    assign yr = (y_reg + RND) >>> mprc_pkg::GUARD;

    assign rsp.done = done_reg;
    assign rsp.rx   = rx_reg;
    assign rsp.ry   = ry_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:  if (req.start) state_next = C_SCALE;
            C_SCALE: state_next = C_ITER;
            C_ITER:  if (i_reg == IW'(NSTEP - 1)) state_next = C_ROUND;
            C_ROUND: state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == C_ROUND);
        end
    end

    // Datapath: the half-turn negation, the gain prescale, then micro-rotations and rounding.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            C_IDLE: begin
                xn_reg    <= req.neg ? -req.x : req.x;
                yn_reg    <= req.neg ? -req.y : req.y;
                extra_reg <= req.extra;
                z_reg     <= req.z;
            end
            C_SCALE: begin
                x_reg <= extra_reg ? CW'(px >>> (PRESHIFT + 1)) : CW'(px >>> PRESHIFT);
                y_reg <= extra_reg ? CW'(py >>> (PRESHIFT + 1)) : CW'(py >>> PRESHIFT);
                i_reg <= '0;
            end
            C_ITER: begin
                if (z_reg >= 0) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - mprc_pkg::atan_q24(5'(i_reg));
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + mprc_pkg::atan_q24(5'(i_reg));
                end
                i_reg <= i_reg + 1'b1;
            end
            C_ROUND: begin
                rx_reg <= RW'(xr);
                ry_reg <= RW'(yr);
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/mprc_norm.sv
// Perpendicular offset unit for vector lines: direction, length by square root,
// and the two rounded ratios by long division. Depends on mprc_pkg.
module mprc_norm (
    input  logic                aclk,
    input  logic                aresetn,
    input  mprc_pkg::norm_req_t req,
    output mprc_pkg::norm_rsp_t rsp
);

    localparam int RW = mprc_pkg::RW;
    localparam int OW = mprc_pkg::OW;
    localparam int DW = RW + 1;

    typedef enum logic [9:0] {
        N_IDLE  = 10'b0000000001,
        N_DIFF  = 10'b0000000010,
        N_HALF  = 10'b0000000100,
        N_SQ    = 10'b0000001000,
        N_SUM   = 10'b0000010000,
        N_SQRT  = 10'b0000100000,
        N_MUL   = 10'b0001000000,
        N_DLOAD = 10'b0010000000,
        N_DIV   = 10'b0100000000,
        N_SIGN  = 10'b1000000000
    } n_state_t;

    n_state_t             state_reg, state_next;
    logic signed [RW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [31:0]   w_reg;
    logic                 sdx_reg, sdy_reg;
    logic [DW-1:0]        mx_reg, my_reg;
    logic [59:0]          sqx_reg, sqy_reg;
    logic [61:0]          n_reg;
    logic [33:0]          rem_reg;
    logic [30:0]          root_reg;
    logic [4:0]           cnt_reg;
    logic [61:0]          prx_reg, pry_reg;
    logic                 sel_x_reg;
    logic [32:0]          drem_reg;
    logic [31:0]          dlo_reg;
    logic [31:0]          q_reg, qy_reg;
    logic                 done_reg;
    logic signed [OW-1:0] ox_reg, oy_reg;

    logic signed [DW-1:0] dx, dy;
    logic                 dzero;
    logic [33:0]          remsh, trial;
    logic [31:0]          aw;
    logic [62:0]          dvd;
    logic [32:0]          dremsh;
    logic [31:0]          dvsr;
    logic                 big;

    assign dx    = DW'(x2_reg) - DW'(x1_reg);
    assign dy    = DW'(y2_reg) - DW'(y1_reg);
    assign dzero = (dx == '0) && (dy == '0);
    assign big   = (mx_reg[DW-1:30] != '0) || (my_reg[DW-1:30] != '0);
    assign remsh = {rem_reg[31:0], n_reg[61:60]};
    assign trial = {1'b0, root_reg, 2'b01};
    assign aw    = w_reg[31] ? 32'(-w_reg) : 32'(w_reg);
    assign dvd   = (sel_x_reg ? 63'(prx_reg) : 63'(pry_reg)) + 63'(root_reg);
    assign dremsh = {drem_reg[31:0], dlo_reg[31]};
    assign dvsr  = {root_reg, 1'b0};

    assign rsp.done = done_reg;
    assign rsp.ox   = ox_reg;
    assign rsp.oy   = oy_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            N_IDLE:  if (req.start) state_next = N_DIFF;
            N_DIFF:  state_next = N_HALF;
            N_HALF:  if (!big) state_next = N_SQ;
            N_SQ:    state_next = N_SUM;
            N_SUM:   state_next = N_SQRT;
            N_SQRT:  if (cnt_reg == 5'd30) state_next = N_MUL;
            N_MUL:   state_next = N_DLOAD;
            N_DLOAD: state_next = N_DIV;
            N_DIV: begin
                if (cnt_reg == 5'd31) state_next = sel_x_reg ? N_SIGN : N_DLOAD;
            end
            N_SIGN:  state_next = N_IDLE;
            default: state_next = N_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == N_SIGN);
        end
    end

    // Datapath, one step of the current operation per cycle.
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            N_IDLE: begin
                x1_reg <= req.x1;
                y1_reg <= req.y1;
                x2_reg <= req.x2;
                y2_reg <= req.y2;
                w_reg  <= req.w;
            end
            N_DIFF: begin
                // Coincident endpoints take the direction (1,0).
                sdx_reg <= dx[DW-1];
                sdy_reg <= dy[DW-1];
                mx_reg  <= dzero ? DW'(1) : (dx[DW-1] ? DW'(-dx) : DW'(dx));
                my_reg  <= dy[DW-1] ? DW'(-dy) : DW'(dy);
            end
            N_HALF: begin
                if (big) begin
                    mx_reg <= mx_reg >> 1;
                    my_reg <= my_reg >> 1;
                end
            end
            N_SQ: begin
                sqx_reg <= mx_reg[29:0] * mx_reg[29:0];
                sqy_reg <= my_reg[29:0] * my_reg[29:0];
            end
            N_SUM: begin
                n_reg    <= 62'(sqx_reg) + 62'(sqy_reg);
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= '0;
            end
            N_SQRT: begin
                // Two radicand bits per cycle, restoring square root.
                if (remsh >= trial) begin
                    rem_reg  <= remsh - trial;
                    root_reg <= {root_reg[29:0], 1'b1};
                end else begin
                    rem_reg  <= remsh;
                    root_reg <= {root_reg[29:0], 1'b0};
                end
                n_reg   <= n_reg << 2;
                cnt_reg <= (cnt_reg == 5'd30) ? 5'd0 : cnt_reg + 1'b1;
            end
            N_MUL: begin
                prx_reg   <= mx_reg[29:0] * aw;
                pry_reg   <= my_reg[29:0] * aw;
                sel_x_reg <= 1'b0;
            end
            N_DLOAD: begin
                drem_reg <= {2'b00, dvd[62:32]};
                dlo_reg  <= dvd[31:0];
                cnt_reg  <= '0;
            end
            N_DIV: begin
                // One quotient bit per cycle; the quotient fits in 32 bits.
                if (dremsh >= 33'(dvsr)) begin
                    drem_reg <= dremsh - 33'(dvsr);
                    q_reg    <= {q_reg[30:0], 1'b1};
                end else begin
                    drem_reg <= dremsh;
                    q_reg    <= {q_reg[30:0], 1'b0};
                end
                dlo_reg <= dlo_reg << 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 5'd31 && !sel_x_reg) begin
                    qy_reg    <= (dremsh >= 33'(dvsr)) ? {q_reg[30:0], 1'b1}
                                                       : {q_reg[30:0], 1'b0};
                    sel_x_reg <= 1'b1;
                end
            end
            N_SIGN: begin
                ox_reg <= (sdy_reg != w_reg[31]) ? OW'(qy_reg) : -OW'(qy_reg);
                oy_reg <= (sdx_reg != w_reg[31]) ? -OW'(q_reg) : OW'(q_reg);
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/mprc_back.sv
// Back end: takes classified primitives from the queue, drives the rotation and
// offset units, and holds the result word register. Depends on mprc_pkg.
module mprc_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    output logic                             q_pop,
    input  mprc_pkg::q_entry_t               q_rdata,
    output mprc_pkg::rot_req_t               rot_req,
    input  mprc_pkg::rot_rsp_t               rot_rsp,
    output mprc_pkg::norm_req_t              norm_req,
    input  mprc_pkg::norm_rsp_t              norm_rsp,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mprc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int PW = mprc_pkg::PW;
    localparam int RW = mprc_pkg::RW;
    localparam int OW = mprc_pkg::OW;
    localparam int SW = mprc_pkg::SW;

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_ROT   = 6'b000010,
        B_RWAIT = 6'b000100,
        B_NORM  = 6'b001000,
        B_NWAIT = 6'b010000,
        B_OUT   = 6'b100000
    } b_state_t;

    b_state_t             state_reg, state_next;
    mprc_pkg::q_entry_t   it_reg;
    logic [1:0]           k_reg;
    logic signed [RW-1:0] cx_reg, cy_reg;
    logic signed [RW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [OW-1:0] ox_reg, oy_reg;
    logic                 m_tvalid_reg;
    logic [31:0]          m_x_reg, m_y_reg, m_d_reg;
    logic                 m_exp_reg, m_circ_reg, m_last_reg;

    logic                 is_circle, is_vector, is_center, last_res, load;
    logic signed [PW-1:0] px, py;
    logic signed [RW-1:0] bx, by;
    logic signed [SW-1:0] vx, vy, res_x, res_y;

    assign is_circle = (it_reg.cmd == mprc_pkg::CMD_CIRCLE);
    assign is_vector = (it_reg.cmd == mprc_pkg::CMD_VECTOR);
    assign is_center = (it_reg.cmd == mprc_pkg::CMD_CENTER);
    assign last_res  = is_circle || (k_reg == 2'd3);
    assign load      = (state_reg == B_OUT) && (!m_tvalid_reg || m_tready);
    assign q_pop     = (state_reg == B_IDLE) && !q_empty;

    // Point to rotate for the current corner index.
    always_comb begin
        unique case (it_reg.cmd)
            mprc_pkg::CMD_CIRCLE: begin
                px = PW'(it_reg.ax);
                py = PW'(it_reg.ay);
            end
            mprc_pkg::CMD_VECTOR: begin
                px = k_reg[0] ? PW'(it_reg.bx) : PW'(it_reg.ax);
                py = k_reg[0] ? PW'(it_reg.by) : PW'(it_reg.ay);
            end
            mprc_pkg::CMD_CENTER: begin
                // Centre line corners carry one extra fraction bit.
                px = (k_reg == 2'd0 || k_reg == 2'd3)
                   ? (PW'(it_reg.ax) <<< 1) - PW'(it_reg.w)
                   : (PW'(it_reg.ax) <<< 1) + PW'(it_reg.w);
                py = k_reg[1] ? (PW'(it_reg.ay) <<< 1) + PW'(it_reg.h)
                              : (PW'(it_reg.ay) <<< 1) - PW'(it_reg.h);
            end
            mprc_pkg::CMD_LOWLEFT: begin
                px = (k_reg == 2'd1 || k_reg == 2'd2) ? PW'(it_reg.ax) + PW'(it_reg.w)
                                                      : PW'(it_reg.ax);
                py = k_reg[1] ? PW'(it_reg.ay) + PW'(it_reg.h) : PW'(it_reg.ay);
            end
            default: begin
                px = '0;
                py = '0;
            end
        endcase
    end

    assign rot_req.start = (state_reg == B_ROT);
    assign rot_req.x     = px;
    assign rot_req.y     = py;
    assign rot_req.extra = is_center;
    assign rot_req.z     = it_reg.z;
    assign rot_req.neg   = it_reg.neg;

    assign norm_req.start = (state_reg == B_NORM);
    assign norm_req.x1    = x1_reg;
    assign norm_req.y1    = y1_reg;
    assign norm_req.x2    = x2_reg;
    assign norm_req.y2    = y2_reg;
    assign norm_req.w     = it_reg.w;

    // Vector line corners: start-o, end-o, end+o, start+o.
    always_comb begin
        bx = (k_reg == 2'd0 || k_reg == 2'd3) ? x1_reg : x2_reg;
        by = (k_reg == 2'd0 || k_reg == 2'd3) ? y1_reg : y2_reg;
        vx = k_reg[1] ? SW'(bx) + SW'(ox_reg) : SW'(bx) - SW'(ox_reg);
        vy = k_reg[1] ? SW'(by) + SW'(oy_reg) : SW'(by) - SW'(oy_reg);
        res_x = is_vector ? vx : SW'(cx_reg);
        res_y = is_vector ? vy : SW'(cy_reg);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (!q_empty) state_next = B_ROT;
            B_ROT:   state_next = B_RWAIT;
            B_RWAIT: begin
                if (rot_rsp.done) begin
                    if (is_vector) begin
                        state_next = k_reg[0] ? B_NORM : B_ROT;
                    end else begin
                        state_next = B_OUT;
                    end
                end
            end
            B_NORM:  state_next = B_NWAIT;
            B_NWAIT: if (norm_rsp.done) state_next = B_OUT;
            B_OUT: begin
                if (load) begin
                    if (last_res) begin
                        state_next = B_IDLE;
                    end else begin
                        state_next = is_vector ? B_OUT : B_ROT;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item, corner index and intermediate results.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            it_reg <= q_rdata;
            k_reg  <= 2'd0;
        end
        if (state_reg == B_RWAIT && rot_rsp.done) begin
            cx_reg <= rot_rsp.rx;
            cy_reg <= rot_rsp.ry;
            if (k_reg[0]) begin
                x2_reg <= rot_rsp.rx;
                y2_reg <= rot_rsp.ry;
            end else begin
                x1_reg <= rot_rsp.rx;
                y1_reg <= rot_rsp.ry;
            end
            if (is_vector) k_reg <= k_reg[0] ? 2'd0 : 2'd1;
        end
        if (state_reg == B_NWAIT && norm_rsp.done) begin
            ox_reg <= norm_rsp.ox;
            oy_reg <= norm_rsp.oy;
        end
        if (load) begin
            m_x_reg    <= mprc_pkg::sat32(res_x);
            m_y_reg    <= mprc_pkg::sat32(res_y);
            m_d_reg    <= is_circle ? it_reg.w : '0;
            m_exp_reg  <= it_reg.exposed;
            m_circ_reg <= is_circle;
            m_last_reg <= last_res;
            if (!last_res) k_reg <= k_reg + 1'b1;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_exp_reg, m_d_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_circ_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: rtl/macro_primitive_rotate_corners.sv
// Top level of the aperture macro primitive rotation block.
// Instantiates mprc_front, mprc_queue, mprc_back, mprc_cordic and mprc_norm; uses mprc_pkg.
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | one primitive word; tuser holds its kind
//  m_      | out | m_tvalid/m_tready  | one centre or corner word; tlast ends a primitive
//
// The front takes one word at a time: it runs KQ = max(1, 18 - FRAC_BITS) remainder
// steps, wrap, half wrap and fold before it pushes, and holds while the queue is full.
// The back does one CORDIC rotation of NSTEP = min(CORDIC_STEPS, 30) steps per point:
// one for a circle, four for a centre or lower-left line, and two for a vector line,
// whose square root and two divisions add on.
// Reset is synchronous and clears only control state; a stalled m_ side holds the back,
// and the two-word queue lets the front keep accepting meanwhile.
module macro_primitive_rotate_corners #(
    parameter int FRAC_BITS    = mprc_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = mprc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // exposure_code, width, height, point_a_x, point_a_y, point_b_x, point_b_y, angle_deg
    input  logic [mprc_pkg::S_TDATA_W-1:0]   s_tdata,
    // cmd
    input  logic [mprc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_x, out_y, diameter, exposed
    output logic [mprc_pkg::M_TDATA_W-1:0]   m_tdata,
    // is_circle
    output logic                             m_tuser,
    output logic                             m_tlast
);

    logic                q_push, q_full, q_pop, q_empty;
    mprc_pkg::q_entry_t  q_wdata, q_rdata;
    mprc_pkg::rot_req_t  rot_req;
    mprc_pkg::rot_rsp_t  rot_rsp;
    mprc_pkg::norm_req_t norm_req;
    mprc_pkg::norm_rsp_t norm_rsp;

    mprc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_full   (q_full),
        .q_wdata  (q_wdata)
    );

    mprc_queue #(.DEPTH(mprc_pkg::QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rdata   (q_rdata),
        .empty   (q_empty)
    );

    mprc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_rdata  (q_rdata),
        .rot_req  (rot_req),
        .rot_rsp  (rot_rsp),
        .norm_req (norm_req),
        .norm_rsp (norm_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mprc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (rot_req),
        .rsp     (rot_rsp)
    );

    mprc_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (norm_req),
        .rsp     (norm_rsp)
    );

endmodule

FILE: rtl/mprc_checker.sv
// Port-level checks for the macro primitive rotation block, attached by bind.
// Depends on the top level's ports only.
module mprc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         m_tuser,
    input logic         m_tlast
);

    // No result word may be offered right after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // A stalled result word holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // A circle is a single-word primitive.
    a_circle_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("circle word without last");

    // Corners carry no diameter.
    a_corner_diam: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[95:64] == 32'd0)
        else $error("corner word with nonzero diameter");

    // The front reduces the angle before it takes another word.
    a_front_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("front accepted back-to-back words");

endmodule

bind macro_primitive_rotate_corners mprc_checker u_mprc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
